// ===== src/llsa_pkg.sv =====
// Package for the lane line slope averager: shared widths, divider operand
// selects and the command/status structs between controller and datapath.
// No dependencies.
package llsa_pkg;

	localparam int COORD_BITS_DEF   = 12;
	localparam int MAX_SEGMENTS_DEF = 256;
	localparam int FRAC_BITS        = 16;
	localparam int SUM_W            = 48;
	localparam int DIV_W            = 50;
	localparam int IT_W             = $clog2(DIV_W + 1);
	localparam int CFG_W            = 12;
	localparam int IN_W             = 12;
	localparam int X_W              = 16;
	localparam logic [CFG_W-1:0] ROWS_RESET = 12'd720;

	typedef enum logic [2:0] {
		DS_SLOPE,
		DS_MAVG,
		DS_CAVG,
		DS_XB,
		DS_XT
	} div_sel_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} res_status_t;

	typedef struct packed {
		logic     div_start;
		div_sel_t div_sel;
		logic     mul;
		logic     acc;
		logic     side;
		logic     out_load;
		logic     eof;
		logic     clear;
	} cmd_t;

	typedef struct packed {
		logic has_seg;
		logic last;
		logic seg_ok;
		logic div_done;
		logic left_nz;
		logic right_nz;
		logic m_zero;
	} stat_t;

endpackage

// ===== src/llsa_ctrl.sv =====
// Controller of the lane line slope averager: sequences segment accumulation
// and per-side emission. Depends on llsa_pkg.
module llsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  llsa_pkg::stat_t stat,
	output llsa_pkg::cmd_t  cmd
);
	import llsa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_SLOPE, S_SLOPE_W, S_MUL, S_ACC, S_FRAME,
		S_AVGM, S_AVGM_W, S_AVGC, S_AVGC_W, S_XB, S_XB_W, S_XT, S_XT_W, S_OUT
	} state_t;

	state_t state_q;
	logic   side_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.div_sel  = DS_SLOPE;
		cmd.side     = side_q;
		cmd.eof      = side_q || !stat.right_nz;
		case (state_q)
			S_SLOPE: begin
				cmd.div_start = 1'b1;
			end
			S_MUL: cmd.mul = 1'b1;
			S_ACC: cmd.acc = 1'b1;
			S_FRAME: cmd.clear = !stat.left_nz && !stat.right_nz;
			S_AVGM: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_MAVG;
			end
			S_AVGM_W: cmd.div_sel = DS_MAVG;
			S_AVGC: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_CAVG;
			end
			S_AVGC_W: cmd.div_sel = DS_CAVG;
			S_XB: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_XB;
			end
			S_XB_W: cmd.div_sel = DS_XB;
			S_XT: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_XT;
			end
			S_XT_W: cmd.div_sel = DS_XT;
			S_OUT: begin
				cmd.out_load = out_free;
				cmd.clear    = out_free && (side_q || !stat.right_nz);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			side_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_CHECK;
				S_CHECK: begin
					if (stat.has_seg && stat.seg_ok) state_q <= S_SLOPE;
					else if (stat.last) state_q <= S_FRAME;
					else state_q <= S_IDLE;
				end
				S_SLOPE: state_q <= S_SLOPE_W;
				S_SLOPE_W: if (stat.div_done) state_q <= S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: state_q <= stat.last ? S_FRAME : S_IDLE;
				S_FRAME: begin
					if (stat.left_nz) begin
						side_q  <= 1'b0;
						state_q <= S_AVGM;
					end else if (stat.right_nz) begin
						side_q  <= 1'b1;
						state_q <= S_AVGM;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_AVGM: state_q <= S_AVGM_W;
				S_AVGM_W: if (stat.div_done) state_q <= S_AVGC;
				S_AVGC: state_q <= S_AVGC_W;
				// zero average slope: no column divides, x comes from the sign
				S_AVGC_W: if (stat.div_done) state_q <= stat.m_zero ? S_OUT : S_XB;
				S_XB: state_q <= S_XB_W;
				S_XB_W: if (stat.div_done) state_q <= S_XT;
				S_XT: state_q <= S_XT_W;
				S_XT_W: if (stat.div_done) state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						if (!side_q && stat.right_nz) begin
							side_q  <= 1'b1;
							state_q <= S_AVGM;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/llsa_div.sv =====
// Radix-2 restoring divider on magnitudes with sign fix-up, truncating
// toward zero. Iteration count set per start. No dependencies.
module llsa_div #(
	parameter int DW = 50,
	parameter int IW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DW-1:0]        num_mag,
	input  logic                 num_neg,
	input  logic [DW-1:0]        den_mag,
	input  logic                 den_neg,
	input  logic [IW-1:0]        iters,
	output logic                 done,
	output logic signed [DW:0]   quo
);
	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic [IW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic          ge;

	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign ge     = (rem_sh >= {1'b0, den_q});
	assign done   = done_q;
	assign quo    = neg_q ? -signed'({1'b0, quo_q}) : signed'({1'b0, quo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= iters;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == IW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			// left-align the dividend so only iters steps are needed
			quo_q <= num_mag << (IW'(DW) - iters);
			den_q <= den_mag;
			neg_q <= num_neg ^ den_neg;
		end else if (run_q) begin
			rem_q <= ge ? DW'(rem_sh - {1'b0, den_q}) : DW'(rem_sh);
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

endmodule

// ===== src/llsa_dp.sv =====
// Datapath of the lane line slope averager: input capture, slope/intercept,
// saturating side sums, averaging and column evaluation. Uses llsa_pkg, llsa_div.
module llsa_dp #(
	parameter int COORD_BITS   = llsa_pkg::COORD_BITS_DEF,
	parameter int MAX_SEGMENTS = llsa_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_accept,
	input  logic [llsa_pkg::IN_W-1:0]         x_start,
	input  logic [llsa_pkg::IN_W-1:0]         y_start,
	input  logic [llsa_pkg::IN_W-1:0]         x_end,
	input  logic [llsa_pkg::IN_W-1:0]         y_end,
	input  logic                              has_segment,
	input  logic                              last,
	input  logic [llsa_pkg::CFG_W-1:0]        rows_bot,
	input  logic [llsa_pkg::CFG_W-1:0]        rows_top,
	input  llsa_pkg::cmd_t                    cmd,
	output llsa_pkg::stat_t                   stat,
	output logic                              side,
	output logic signed [llsa_pkg::X_W-1:0]   x_bottom,
	output logic [llsa_pkg::CFG_W-1:0]        y_bottom,
	output logic signed [llsa_pkg::X_W-1:0]   x_top,
	output logic [llsa_pkg::CFG_W-1:0]        y_top,
	output logic [1:0]                        status,
	output logic                              end_of_frame
);
	import llsa_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int DXW = CB + 1;
	localparam int MW  = CB + FRAC_BITS + 1;
	localparam int XSW = CB + 1;
	localparam int PW  = MW + XSW + 1;
	localparam int CW  = PW + 1;
	localparam int AW  = ((CW > SUM_W) ? CW : SUM_W) + 1;
	localparam int NW  = $clog2(MAX_SEGMENTS + 1);
	localparam logic signed [AW-1:0] SMAX = {{(AW-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
	localparam logic signed [AW-1:0] SMIN = {{(AW-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};
	localparam logic signed [X_W-1:0] XMAX = {1'b0, {(X_W-1){1'b1}}};
	localparam logic signed [X_W-1:0] XMIN = {1'b1, {(X_W-1){1'b0}}};

	function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
		input logic signed [CW-1:0] b);
		logic signed [AW-1:0] s;
		s = AW'(a) + AW'(b);
		if (s > SMAX) s = SMAX;
		else if (s < SMIN) s = SMIN;
		return SUM_W'(s);
	endfunction

	// {saturated, value}
	function automatic logic [X_W:0] sat_x(input logic signed [DIV_W:0] q);
		if (q > DIV_W'(XMAX)) return {1'b1, XMAX};
		if (q < DIV_W'(XMIN)) return {1'b1, XMIN};
		return {1'b0, X_W'(q)};
	endfunction

	function automatic logic signed [X_W-1:0] sgn_x(input logic signed [DIV_W-1:0] n);
		if (n > 0) return XMAX;
		if (n < 0) return XMIN;
		return '0;
	endfunction

	logic [CB-1:0] x1_q, y1_q, x2_q, y2_q;
	logic          has_q, last_q;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			x1_q   <= CB'(x_start);
			y1_q   <= CB'(y_start);
			x2_q   <= CB'(x_end);
			y2_q   <= CB'(y_end);
			has_q  <= has_segment;
			last_q <= last;
		end
	end

	logic signed [DXW-1:0] dx, dy;
	logic [CB-1:0]         dx_abs, dy_abs;
	logic [XSW-1:0]        xs, ys;

	assign dx     = signed'({1'b0, x2_q}) - signed'({1'b0, x1_q});
	assign dy     = signed'({1'b0, y2_q}) - signed'({1'b0, y1_q});
	assign dx_abs = dx[DXW-1] ? CB'(-dx) : CB'(dx);
	assign dy_abs = dy[DXW-1] ? CB'(-dy) : CB'(dy);
	assign xs     = {1'b0, x1_q} + {1'b0, x2_q};
	assign ys     = {1'b0, y1_q} + {1'b0, y2_q};

	logic signed [MW-1:0]    m_q;
	logic signed [PW-1:0]    prod_q;
	logic signed [CW-1:0]    ysf, diff, dadj, icpt;

	always_ff @(posedge clk) begin
		if (cmd.mul) prod_q <= m_q * signed'({1'b0, xs});
	end

	assign ysf  = signed'(CW'({ys, {FRAC_BITS{1'b0}}}));
	assign diff = ysf - CW'(prod_q);
	// halve toward zero
	assign dadj = diff + signed'(CW'(diff[CW-1]));
	assign icpt = dadj >>> 1;

	logic signed [SUM_W-1:0] ls_q, li_q, rs_q, ri_q;
	logic [NW-1:0]           lc_q, rc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_q <= '0;
			li_q <= '0;
			rs_q <= '0;
			ri_q <= '0;
			lc_q <= '0;
			rc_q <= '0;
		end else if (cmd.clear) begin
			ls_q <= '0;
			li_q <= '0;
			rs_q <= '0;
			ri_q <= '0;
			lc_q <= '0;
			rc_q <= '0;
		end else if (cmd.acc) begin
			if (m_q[MW-1]) begin
				ls_q <= sat_add(ls_q, CW'(m_q));
				li_q <= sat_add(li_q, icpt);
				lc_q <= lc_q + 1'b1;
			end else begin
				rs_q <= sat_add(rs_q, CW'(m_q));
				ri_q <= sat_add(ri_q, icpt);
				rc_q <= rc_q + 1'b1;
			end
		end
	end

	logic signed [SUM_W-1:0] ssum, isum, mavg_q, cavg_q;
	logic [SUM_W-1:0]        ssum_abs, isum_abs, mavg_abs;
	logic [NW-1:0]           cnt;
	logic signed [DIV_W-1:0] numb, numt;
	logic [DIV_W-1:0]        numb_abs, numt_abs;

	assign ssum     = cmd.side ? rs_q : ls_q;
	assign isum     = cmd.side ? ri_q : li_q;
	assign cnt      = cmd.side ? rc_q : lc_q;
	assign ssum_abs = ssum[SUM_W-1] ? SUM_W'(-ssum) : SUM_W'(ssum);
	assign isum_abs = isum[SUM_W-1] ? SUM_W'(-isum) : SUM_W'(isum);
	assign mavg_abs = mavg_q[SUM_W-1] ? SUM_W'(-mavg_q) : SUM_W'(mavg_q);
	assign numb = signed'(DIV_W'({rows_bot, {FRAC_BITS{1'b0}}})) - DIV_W'(cavg_q);
	assign numt = signed'(DIV_W'({rows_top, {FRAC_BITS{1'b0}}})) - DIV_W'(cavg_q);
	assign numb_abs = numb[DIV_W-1] ? DIV_W'(-numb) : DIV_W'(numb);
	assign numt_abs = numt[DIV_W-1] ? DIV_W'(-numt) : DIV_W'(numt);

	logic [DIV_W-1:0]        d_num, d_den;
	logic                    d_nneg, d_dneg, d_done;
	logic [IT_W-1:0]         d_it;
	logic signed [DIV_W:0]   d_quo;

	always_comb begin
		d_num  = '0;
		d_nneg = 1'b0;
		d_den  = '0;
		d_dneg = 1'b0;
		d_it   = '0;
		case (cmd.div_sel)
			DS_SLOPE: begin
				d_num  = DIV_W'(dy_abs) << FRAC_BITS;
				d_nneg = dy[DXW-1];
				d_den  = DIV_W'(dx_abs);
				d_dneg = dx[DXW-1];
				d_it   = IT_W'(CB + FRAC_BITS);
			end
			DS_MAVG: begin
				d_num  = DIV_W'(ssum_abs);
				d_nneg = ssum[SUM_W-1];
				d_den  = DIV_W'(cnt);
				d_it   = IT_W'(SUM_W);
			end
			DS_CAVG: begin
				d_num  = DIV_W'(isum_abs);
				d_nneg = isum[SUM_W-1];
				d_den  = DIV_W'(cnt);
				d_it   = IT_W'(SUM_W);
			end
			DS_XB: begin
				d_num  = numb_abs;
				d_nneg = numb[DIV_W-1];
				d_den  = DIV_W'(mavg_abs);
				d_dneg = mavg_q[SUM_W-1];
				d_it   = IT_W'(DIV_W);
			end
			DS_XT: begin
				d_num  = numt_abs;
				d_nneg = numt[DIV_W-1];
				d_den  = DIV_W'(mavg_abs);
				d_dneg = mavg_q[SUM_W-1];
				d_it   = IT_W'(DIV_W);
			end
			default: ;
		endcase
	end

	llsa_div #(
		.DW(DIV_W),
		.IW(IT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num_mag(d_num),
		.num_neg(d_nneg),
		.den_mag(d_den),
		.den_neg(d_dneg),
		.iters  (d_it),
		.done   (d_done),
		.quo    (d_quo)
	);

	logic signed [X_W-1:0] xb_q, xt_q;
	logic                  satb_q, satt_q;

	always_ff @(posedge clk) begin
		if (d_done) begin
			case (cmd.div_sel)
				DS_SLOPE: m_q <= MW'(d_quo);
				DS_MAVG:  mavg_q <= SUM_W'(d_quo);
				DS_CAVG:  cavg_q <= SUM_W'(d_quo);
				DS_XB:    {satb_q, xb_q} <= sat_x(d_quo);
				DS_XT:    {satt_q, xt_q} <= sat_x(d_quo);
				default: ;
			endcase
		end
	end

	logic                  side_q, eof_q;
	logic signed [X_W-1:0] xbo_q, xto_q;
	logic [CFG_W-1:0]      ybo_q, yto_q;
	res_status_t           st_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			side_q <= cmd.side;
			eof_q  <= cmd.eof;
			ybo_q  <= rows_bot;
			yto_q  <= rows_top;
			if (mavg_q == '0) begin
				xbo_q <= sgn_x(numb);
				xto_q <= sgn_x(numt);
				st_q  <= ST_ZERO;
			end else begin
				xbo_q <= xb_q;
				xto_q <= xt_q;
				st_q  <= (satb_q || satt_q) ? ST_SAT : ST_OK;
			end
		end
	end

	assign side         = side_q;
	assign x_bottom     = xbo_q;
	assign y_bottom     = ybo_q;
	assign x_top        = xto_q;
	assign y_top        = yto_q;
	assign status       = st_q;
	assign end_of_frame = eof_q;

	assign stat.has_seg  = has_q;
	assign stat.last     = last_q;
	assign stat.seg_ok   = (dx != '0) && (({1'b0, lc_q} + {1'b0, rc_q}) < (NW+1)'(MAX_SEGMENTS));
	assign stat.div_done = d_done;
	assign stat.left_nz  = (lc_q != '0);
	assign stat.right_nz = (rc_q != '0);
	assign stat.m_zero   = (mavg_q == '0);

endmodule

// ===== src/lane_line_slope_averager.sv =====
// Lane line slope averager, top level: APB register, controller, datapath.
// Segment item: in_ready stays low from accept until the radix-2 slope divide, multiply and
// accumulate are done. Frame end, per side with segments: two 48-step averages and two
// 50-step column divides on the one shared divider (the column divides are skipped when
// the average slope is zero); output register decouples out.
// Reset (arst_n low, async): sums and counts cleared, frame_rows = 720, no result pending.
// Depends on llsa_pkg, llsa_ctrl, llsa_dp.
module lane_line_slope_averager #(
	parameter int COORD_BITS   = llsa_pkg::COORD_BITS_DEF,
	parameter int MAX_SEGMENTS = llsa_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [llsa_pkg::IN_W-1:0]       x_start,
	input  logic [llsa_pkg::IN_W-1:0]       y_start,
	input  logic [llsa_pkg::IN_W-1:0]       x_end,
	input  logic [llsa_pkg::IN_W-1:0]       y_end,
	input  logic                            has_segment,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            side,
	output logic signed [llsa_pkg::X_W-1:0] x_bottom,
	output logic [llsa_pkg::CFG_W-1:0]      y_bottom,
	output logic signed [llsa_pkg::X_W-1:0] x_top,
	output logic [llsa_pkg::CFG_W-1:0]      y_top,
	output logic [1:0]                      status,
	output logic                            end_of_frame
);
	import llsa_pkg::*;

	localparam logic [15:0] RECIP5 = 16'd52429;

	logic [CFG_W-1:0] frame_rows_q;
	logic [CFG_W+1:0] rows3;
	logic [CFG_W+17:0] rows_prod;
	logic [CFG_W-1:0] rows_top;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {{(32-CFG_W){1'b0}}, frame_rows_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= ROWS_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			frame_rows_q <= pwdata[CFG_W-1:0];
		end
	end

	// rows*3/5 by reciprocal multiply, exact over the 12-bit range
	assign rows3     = {2'b00, frame_rows_q} + {1'b0, frame_rows_q, 1'b0};
	assign rows_prod = rows3 * RECIP5;
	assign rows_top  = rows_prod[CFG_W+17:18];

	cmd_t  cmd;
	stat_t stat;

	llsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	llsa_dp #(
		.COORD_BITS  (COORD_BITS),
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_accept   (in_valid && in_ready),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.has_segment (has_segment),
		.last        (last),
		.rows_bot    (frame_rows_q),
		.rows_top    (rows_top),
		.cmd         (cmd),
		.stat        (stat),
		.side        (side),
		.x_bottom    (x_bottom),
		.y_bottom    (y_bottom),
		.x_top       (x_top),
		.y_top       (y_top),
		.status      (status),
		.end_of_frame(end_of_frame)
	);

endmodule

// ===== src/llsa_check.sv =====
// Port-level checker for the lane line slope averager, bound to the top level.
// Depends on lane_line_slope_averager ports only.
module llsa_check (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               side,
	input logic signed [15:0] x_bottom,
	input logic [11:0]        y_bottom,
	input logic signed [15:0] x_top,
	input logic [11:0]        y_top,
	input logic [1:0]         status,
	input logic               end_of_frame
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_bottom) && $stable(x_top)
			&& $stable(status) && $stable(side))
		else $error("result beat changed while stalled");

	a_top_above: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> y_top <= y_bottom)
		else $error("top row below bottom row");

	a_zero_slope: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == 2'd2 |-> (x_bottom == 16'sd32767 || x_bottom == -16'sd32768
			|| x_bottom == 16'sd0) && (x_top == 16'sd32767 || x_top == -16'sd32768
			|| x_top == 16'sd0))
		else $error("zero slope result not at a rail");

	a_right_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && side |-> end_of_frame)
		else $error("right line not marked end of frame");

endmodule

bind lane_line_slope_averager llsa_check u_check (.*);

// ===== tb/lane_line_slope_averager_test.sv =====
// Testbench for lane_line_slope_averager: drives frames of line segments, predicts the
// averaged left and right lane lines per frame and checks each emitted result.
// Depends on llsa_pkg and the lane_line_slope_averager RTL.
`timescale 1ns / 1ps

class lane_scoreboard;
	localparam longint SUM_HI = 64'sd140737488355327;
	localparam longint SUM_LO = -64'sd140737488355328;

	longint l_slope, l_icpt, r_slope, r_icpt;
	int unsigned l_cnt, r_cnt;
	logic [11:0] rows;
	logic [59:0] lines_due[$];
	int errors;

	function new();
		l_slope = 0; l_icpt = 0; r_slope = 0; r_icpt = 0;
		l_cnt = 0; r_cnt = 0;
		rows = 12'd720;
		errors = 0;
	endfunction

	function longint sat_sum(longint a, longint b);
		longint s;
		s = a + b;
		if (s > SUM_HI) return SUM_HI;
		if (s < SUM_LO) return SUM_LO;
		return s;
	endfunction

	function longint column_at(longint row, longint m, longint c, inout bit sat);
		longint num, q;
		num = row * 65536 - c;
		if (m == 0) begin
			if (num > 0) return 32767;
			if (num < 0) return -32768;
			return 0;
		end
		q = num / m;
		if (q > 32767) begin
			sat = 1;
			return 32767;
		end
		if (q < -32768) begin
			sat = 1;
			return -32768;
		end
		return q;
	endfunction

	// side, x_bottom, y_bottom, x_top, y_top, status, end_of_frame
	function logic [59:0] average_line(bit sd, longint ss, longint is, int unsigned n);
		longint m, c, yb, yt, xb, xt;
		bit sat;
		logic [1:0] st;
		sat = 0;
		m = ss / longint'(n);
		c = is / longint'(n);
		yb = rows;
		yt = (yb * 3) / 5;
		xb = column_at(yb, m, c, sat);
		xt = column_at(yt, m, c, sat);
		st = (m == 0) ? llsa_pkg::ST_ZERO : (sat ? llsa_pkg::ST_SAT : llsa_pkg::ST_OK);
		return {sd, xb[15:0], yb[11:0], xt[15:0], yt[11:0], st, 1'b0};
	endfunction

	function void note_segment(logic [11:0] x1, logic [11:0] y1, logic [11:0] x2,
			logic [11:0] y2, bit has, bit lst);
		longint dx, dy, m, c;
		int k;
		k = 0;
		if (has) begin
			dx = longint'(x2) - longint'(x1);
			dy = longint'(y2) - longint'(y1);
			if (dx != 0 && l_cnt + r_cnt < 256) begin
				m = (dy * 65536) / dx;
				c = ((longint'(y1) + longint'(y2)) * 65536
					- m * (longint'(x1) + longint'(x2))) / 2;
				if (m < 0) begin
					l_slope = sat_sum(l_slope, m);
					l_icpt = sat_sum(l_icpt, c);
					l_cnt++;
				end else begin
					r_slope = sat_sum(r_slope, m);
					r_icpt = sat_sum(r_icpt, c);
					r_cnt++;
				end
			end
		end
		if (lst) begin
			if (l_cnt > 0) begin
				lines_due = {lines_due, average_line(0, l_slope, l_icpt, l_cnt)};
				k++;
			end
			if (r_cnt > 0) begin
				lines_due = {lines_due, average_line(1, r_slope, r_icpt, r_cnt)};
				k++;
			end
			if (k > 0) lines_due[lines_due.size()-1][0] = 1'b1;
			l_slope = 0; l_icpt = 0; r_slope = 0; r_icpt = 0;
			l_cnt = 0; r_cnt = 0;
		end
	endfunction

	function void check_line(logic [59:0] got);
		logic [59:0] want;
		if (lines_due.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected line %h", got);
			return;
		end
		want = lines_due.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display({"line mismatch: side %0d/%0d xb %0d/%0d yb %0d/%0d",
					" xt %0d/%0d yt %0d/%0d st %0d/%0d eof %0d/%0d"},
					want[59], got[59], $signed(want[58:43]), $signed(got[58:43]),
					want[42:31], got[42:31], $signed(want[30:15]), $signed(got[30:15]),
					want[14:3], got[14:3], want[2:1], got[2:1], want[0], got[0]);
		end
	endfunction
endclass

module lane_line_slope_averager_test;
	import llsa_pkg::*;

	localparam int IDLE_FREE = 1700;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	logic [11:0] x_start, y_start, x_end, y_end;
	logic has_segment, last;
	logic out_valid, out_ready;
	logic side;
	logic signed [15:0] x_bottom, x_top;
	logic [11:0] y_bottom, y_top;
	logic [1:0] status;
	logic end_of_frame;

	lane_scoreboard lanes;
	int beats_sent;
	bit hold_off;
	longint cycles;

	lane_line_slope_averager dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_valid = 0; x_start = '0; y_start = '0; x_end = '0; y_end = '0;
		has_segment = 0; last = 0; out_ready = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("lane_line_slope_averager_test failed");
			$finish;
		end
	end
	initial cycles = 0;

	// Check results on the accepting edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			lanes.check_line({side, x_bottom, y_bottom, x_top, y_top, status, end_of_frame});
	end

	// Receiver: random stalls, one long hold-off, no stalls near the end.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 0;
				repeat (3000) @(posedge clk);
				hold_off = 0;
			end
			if (beats_sent < IDLE_FREE && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 16);
				out_ready <= 0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1;
		end
	end

	task automatic write_rows(logic [11:0] v);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= 3'd0; pwdata <= {20'd0, v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		lanes.rows = v;
	endtask

	// Valid stays high into the next beat unless an idle burst drops it.
	task automatic send_beat(logic [11:0] x1, logic [11:0] y1, logic [11:0] x2,
			logic [11:0] y2, bit has, bit lst);
		int n;
		if (beats_sent < IDLE_FREE && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 16);
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		x_start <= x1; y_start <= y1; x_end <= x2; y_end <= y2;
		has_segment <= has; last <= lst;
		do @(posedge clk); while (!in_ready);
		lanes.note_segment(x1, y1, x2, y2, has, lst);
		if (has || lst) beats_sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (lanes.lines_due.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	// Frame of small-count segments, mostly plausible lanes.
	task automatic random_frame(int segs);
		logic [11:0] a, b, c, d;
		for (int i = 0; i < segs; i++) begin
			a = 12'($urandom); b = 12'($urandom); c = 12'($urandom); d = 12'($urandom);
			if ($urandom_range(0, 9) == 0) c = a;
			if ($urandom_range(0, 9) == 0) d = b;
			if ($urandom_range(0, 3) != 0) begin
				a = 12'($urandom_range(0, 1279)); c = 12'($urandom_range(0, 1279));
				b = 12'($urandom_range(400, 720)); d = 12'($urandom_range(400, 720));
			end
			send_beat(a, b, c, d, $urandom_range(0, 15) != 0, 1'b0);
		end
		send_beat(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
			1'($urandom_range(0, 1)), 1'b1);
	endtask

	initial begin
		logic [11:0] rows_set[5];
		lanes = new();
		beats_sent = 0;
		hold_off = 0;
		rows_set = '{12'd720, 12'd1, 12'd4095, 12'd0, 12'd480};
		@(posedge arst_n);
		@(posedge clk);
		// Directed: extremes, vertical, horizontal, empty frames, ignored item.
		send_beat(12'd0, 12'd0, 12'd4095, 12'd4095, 1'b1, 1'b0);
		send_beat(12'd0, 12'd4095, 12'd4095, 12'd0, 1'b1, 1'b0);
		send_beat(12'd100, 12'd10, 12'd100, 12'd700, 1'b1, 1'b0);
		send_beat(12'd10, 12'd300, 12'd900, 12'd300, 1'b1, 1'b1);
		send_beat(12'd5, 12'd5, 12'd5, 12'd9, 1'b1, 1'b1);
		send_beat(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b1);
		send_beat(12'hfff, 12'hfff, 12'hfff, 12'hfff, 1'b0, 1'b0);
		send_beat(12'd0, 12'd0, 12'd1, 12'd0, 1'b1, 1'b0);
		send_beat(12'd4095, 12'd0, 12'd4094, 12'd4095, 1'b1, 1'b1);
		send_beat(12'd4095, 12'd4095, 12'd0, 12'd0, 1'b1, 1'b0);
		send_beat(12'd1, 12'd4095, 12'd0, 12'd0, 1'b1, 1'b1);
		drain();
		// Overfill: more than 256 segments in one frame.
		for (int i = 0; i < 262; i++)
			send_beat(12'($urandom_range(0, 2000)), 12'($urandom),
				12'($urandom_range(2001, 4095)), 12'($urandom), 1'b1, i == 261);
		drain();
		foreach (rows_set[k]) begin
			write_rows(rows_set[k]);
			if (k == 1) hold_off = 1;
			for (int f = 0; f < 70; f++)
				random_frame($urandom_range(0, 5));
			drain();
		end
		write_rows(12'd720);
		while (beats_sent < 1900) random_frame($urandom_range(0, 4));
		drain();
		if (lanes.errors == 0 && lanes.lines_due.size() == 0) begin
			$display("lane_line_slope_averager_test passed");
		end else begin
			$display("lane_line_slope_averager_test failed");
		end
		$finish;
	end
endmodule
